/* src/cfp_pkg.sv */
// ----------------------------------------------------------------------------
// CSV field parser package
// Shared types and constants for the CSV line field parser.
// ----------------------------------------------------------------------------
`default_nettype none

package cfp_pkg;

	localparam int ByteW       = 8;
	localparam int FieldNumW   = 10;
	localparam int CfgIdxW     = 1;
	localparam int QueueDepth  = 4;
	localparam int QueuePtrW   = $clog2(QueueDepth);
	localparam int QueueCntW   = $clog2(QueueDepth + 1);

	localparam logic [FieldNumW-1:0] MaxFieldIndex = FieldNumW'(1023);

	localparam logic [ByteW-1:0] DelimiterReset = 8'd44;
	localparam logic [ByteW-1:0] QuoteReset     = 8'd34;

	localparam logic [CfgIdxW-1:0] RegDelimiter = 1'b0;
	localparam logic [CfgIdxW-1:0] RegQuote     = 1'b1;

	localparam logic FuncByte = 1'b0;
	localparam logic FuncEol  = 1'b1;

	typedef struct packed {
		logic             func;
		logic [ByteW-1:0] char_byte;
	} in_item_t;

	typedef struct packed {
		logic [ByteW-1:0]     field_char;
		logic                 char_valid;
		logic                 field_end;
		logic                 row_end;
		logic                 empty_line;
		logic [FieldNumW-1:0] field_number;
	} out_item_t;

	typedef struct packed {
		logic             is_eol;
		logic             is_quote;
		logic             is_delim;
		logic [ByteW-1:0] char_byte;
	} class_item_t;

endpackage

`default_nettype wire

/* src/cfp_front.sv */
// ----------------------------------------------------------------------------
// CSV field parser front end
// Holds the delimiter and quote registers and classifies each input byte.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wen,
	input  wire logic [cfp_pkg::CfgIdxW-1:0]  cfg_idx,
	input  wire logic [cfp_pkg::ByteW-1:0]    cfg_data,
	input  wire cfp_pkg::in_item_t            item,
	output cfp_pkg::class_item_t              cls
);

	logic [cfp_pkg::ByteW-1:0] delimiter_q;
	logic [cfp_pkg::ByteW-1:0] quote_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delimiter_q <= cfp_pkg::DelimiterReset;
			quote_q     <= cfp_pkg::QuoteReset;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				cfp_pkg::RegDelimiter: delimiter_q <= cfg_data;
				cfp_pkg::RegQuote:     quote_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cls.is_eol    = (item.func == cfp_pkg::FuncEol);
		cls.is_quote  = (item.char_byte == quote_q);
		cls.is_delim  = (item.char_byte == delimiter_q);
		cls.char_byte = item.char_byte;
	end

endmodule

`default_nettype wire

/* src/cfp_queue.sv */
// ----------------------------------------------------------------------------
// CSV field parser queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire cfp_pkg::class_item_t  push_item,
	output logic                       full,
	input  wire logic                  pop,
	output logic                       empty,
	output cfp_pkg::class_item_t       head
);

	cfp_pkg::class_item_t store_q [cfp_pkg::QueueDepth];

	logic [cfp_pkg::QueuePtrW-1:0] wr_ptr_q;
	logic [cfp_pkg::QueuePtrW-1:0] rd_ptr_q;
	logic [cfp_pkg::QueueCntW-1:0] count_q;

	assign full  = (count_q == cfp_pkg::QueueCntW'(cfp_pkg::QueueDepth));
	assign empty = (count_q == '0);
	assign head  = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* src/cfp_back.sv */
// ----------------------------------------------------------------------------
// CSV field parser back end
// Parse state machine, field counter and registered result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_empty,
	input  wire cfp_pkg::class_item_t  q_head,
	output logic                       q_pop,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output cfp_pkg::out_item_t         out_data
);

	localparam logic [2:0] PhStart     = 3'd0;
	localparam logic [2:0] PhUnquoted  = 3'd1;
	localparam logic [2:0] PhQuoted    = 3'd2;
	localparam logic [2:0] PhQuoteSeen = 3'd3;
	localparam logic [2:0] PhSkip      = 3'd4;

	logic [2:0]                      phase_q;
	logic                            has_bytes_q;
	logic [cfp_pkg::FieldNumW-1:0]   count_q;
	logic                            valid_q;
	cfp_pkg::out_item_t              data_q;

	logic [2:0]                      phase_d;
	logic                            has_bytes_d;
	logic [cfp_pkg::FieldNumW-1:0]   count_d;
	logic [cfp_pkg::FieldNumW-1:0]   count_inc;
	logic                            res_v;
	cfp_pkg::out_item_t              res;

	assign q_pop     = !q_empty && (!valid_q || !out_stall);
	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign count_inc = (count_q < cfp_pkg::MaxFieldIndex) ? count_q + 1'b1 : count_q;

	always_comb begin
		phase_d     = phase_q;
		has_bytes_d = 1'b1;
		count_d     = count_q;
		res_v       = 1'b0;
		res         = '0;
		res.field_number = count_q;
		if (q_head.is_eol) begin
			res_v       = 1'b1;
			res.row_end = 1'b1;
			if (!has_bytes_q) begin
				res.empty_line   = 1'b1;
				res.field_number = '0;
			end else begin
				res.field_end = 1'b1;
			end
			phase_d     = PhStart;
			has_bytes_d = 1'b0;
			count_d     = '0;
		end else begin
			unique case (phase_q)
				PhStart: begin
					if (q_head.is_quote) begin
						phase_d = PhQuoted;
					end else if (q_head.is_delim) begin
						res_v         = 1'b1;
						res.field_end = 1'b1;
						count_d       = count_inc;
					end else begin
						phase_d        = PhUnquoted;
						res_v          = 1'b1;
						res.char_valid = 1'b1;
						res.field_char = q_head.char_byte;
					end
				end
				PhUnquoted: begin
					if (q_head.is_delim) begin
						phase_d       = PhStart;
						res_v         = 1'b1;
						res.field_end = 1'b1;
						count_d       = count_inc;
					end else begin
						res_v          = 1'b1;
						res.char_valid = 1'b1;
						res.field_char = q_head.char_byte;
					end
				end
				PhQuoted: begin
					if (q_head.is_quote) begin
						phase_d = PhQuoteSeen;
					end else begin
						res_v          = 1'b1;
						res.char_valid = 1'b1;
						res.field_char = q_head.char_byte;
					end
				end
				PhQuoteSeen: begin
					if (q_head.is_quote) begin
						phase_d        = PhQuoted;
						res_v          = 1'b1;
						res.char_valid = 1'b1;
						res.field_char = q_head.char_byte;
					end else if (q_head.is_delim) begin
						phase_d       = PhStart;
						res_v         = 1'b1;
						res.field_end = 1'b1;
						count_d       = count_inc;
					end else begin
						phase_d = PhSkip;
					end
				end
				default: begin
					if (q_head.is_delim) begin
						phase_d       = PhStart;
						res_v         = 1'b1;
						res.field_end = 1'b1;
						count_d       = count_inc;
					end else begin
						phase_d = PhSkip;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PhStart;
			has_bytes_q <= 1'b0;
			count_q     <= '0;
			valid_q     <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q     <= phase_d;
				has_bytes_q <= has_bytes_d;
				count_q     <= count_d;
			end
			if (q_pop && res_v) begin
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && res_v) begin
			data_q <= res;
		end
	end

endmodule

`default_nettype wire

/* src/csv_line_field_parser.sv */
// ----------------------------------------------------------------------------
// CSV line field parser
// Splits a byte stream of lines into decoded field characters and field ends.
// ----------------------------------------------------------------------------
// Input beats carry one line byte (func low) or an end-of-line mark (func
// high) on in_valid/in_stall. Output beats on out_valid/out_stall carry one
// decoded field character or a field end; row_end marks the last beat of a
// line, and a line with no bytes gives a single empty_line beat.
// Bytes that give no result (opening quote, quote inside a quoted field,
// dropped bytes after a closing quote) are absorbed without an output beat.
// The front end classifies bytes against the delimiter and quote registers
// and pushes them into a four-entry queue; the back end runs the parse state
// machine and holds the result in an output register.
// Throughput is one byte per cycle while the receiver does not stall, set
// by the state update in the back end. When the receiver stalls, the queue
// fills and in_stall rises. Reset clears the queue, the parser returns to
// field start with field number zero, and the registers return to comma and
// double quote. Registers must be written through cfg_wen, cfg_idx and
// cfg_data while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_line_field_parser (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wen,
	input  wire logic [cfp_pkg::CfgIdxW-1:0]  cfg_idx,
	input  wire logic [cfp_pkg::ByteW-1:0]    cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire cfp_pkg::in_item_t            in_data,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output cfp_pkg::out_item_t                out_data
);

	cfp_pkg::class_item_t cls;
	cfp_pkg::class_item_t q_head;
	logic                 q_full;
	logic                 q_empty;
	logic                 q_pop;
	logic                 q_push;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	cfp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.item     (in_data),
		.cls      (cls)
	);

	cfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (cls),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	cfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

/* src/cfp_checker.sv */
// ----------------------------------------------------------------------------
// CSV field parser checker
// Port-level checks on the output beats of the CSV line field parser.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_checker (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                out_valid,
	input  wire logic                out_stall,
	input  wire cfp_pkg::out_item_t  out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	a_empty_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.empty_line |->
			out_data.row_end && !out_data.field_end && !out_data.char_valid &&
			(out_data.field_number == '0))
		else $error("malformed empty line beat");

	a_char_or_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.char_valid && out_data.field_end))
		else $error("beat carries both a character and a field end");

	a_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.row_end |-> out_data.field_end || out_data.empty_line)
		else $error("row end without field end");

endmodule

bind csv_line_field_parser cfp_checker u_cfp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire

/* tb/sv/csv_field_checker.sv */
// ----------------------------------------------------------------------------
// CSV field parser checker
// Watches the configuration port and both channels of the CSV line field
// parser. It keeps its own copy of the parse state and the delimiter and
// quote registers, works out the output beat that each accepted input beat
// should give, and compares every accepted output beat field by field with
// the oldest outstanding expectation. The failure count and the number of
// outstanding beats go back to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csv_field_checker
	import cfp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CfgIdxW-1:0]   cfg_idx,
	input  logic [ByteW-1:0]     cfg_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  in_item_t             in_data,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  out_item_t            out_data,
	output int                   fail_count,
	output int                   pending
);

	typedef enum logic [2:0] {
		PhFieldStart,
		PhUnquoted,
		PhQuoted,
		PhQuoteSeen,
		PhSkip
	} parse_phase_e;

	parse_phase_e         phase;
	logic                 line_open;
	logic [FieldNumW-1:0] field_idx;
	logic [ByteW-1:0]     delim_reg;
	logic [ByteW-1:0]     quote_reg;
	out_item_t            expected_beats[$];

	task automatic report_mismatch(input string msg);
		if (fail_count < 100) begin
			$display("ERROR at %0t ns: %s", $time, msg);
		end
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
		end
	endtask

	task automatic predict_beat(input in_item_t item, output bit has_beat,
			output out_item_t beat);
		bit take_char;
		bit end_field;
		take_char = 1'b0;
		end_field = 1'b0;
		beat = '0;
		beat.field_number = field_idx;
		has_beat = 1'b1;
		if (item.func == FuncEol) begin
			beat.row_end = 1'b1;
			if (line_open) begin
				beat.field_end = 1'b1;
			end else begin
				beat.empty_line   = 1'b1;
				beat.field_number = '0;
			end
			phase     = PhFieldStart;
			line_open = 1'b0;
			field_idx = '0;
		end else begin
			line_open = 1'b1;
			case (phase)
				PhFieldStart: begin
					if (item.char_byte == quote_reg) begin
						phase = PhQuoted;
					end else if (item.char_byte == delim_reg) begin
						end_field = 1'b1;
					end else begin
						phase     = PhUnquoted;
						take_char = 1'b1;
					end
				end
				PhUnquoted: begin
					if (item.char_byte == delim_reg) end_field = 1'b1;
					else take_char = 1'b1;
				end
				PhQuoted: begin
					if (item.char_byte == quote_reg) phase = PhQuoteSeen;
					else take_char = 1'b1;
				end
				PhQuoteSeen: begin
					if (item.char_byte == quote_reg) begin
						phase     = PhQuoted;
						take_char = 1'b1;
					end else if (item.char_byte == delim_reg) begin
						end_field = 1'b1;
					end else begin
						phase = PhSkip;
					end
				end
				default: begin
					if (item.char_byte == delim_reg) end_field = 1'b1;
				end
			endcase
			if (end_field) begin
				beat.field_end = 1'b1;
				phase = PhFieldStart;
				if (field_idx != MaxFieldIndex) field_idx++;
			end
			beat.char_valid = take_char;
			if (take_char) beat.field_char = item.char_byte;
			has_beat = take_char || end_field;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		bit        has_beat;
		out_item_t beat;
		out_item_t want;
		if (!arst_n) begin
			phase      = PhFieldStart;
			line_open  = 1'b0;
			field_idx  = '0;
			delim_reg  = DelimiterReset;
			quote_reg  = QuoteReset;
			fail_count = 0;
			expected_beats.delete();
			pending <= 0;
		end else begin
			if (cfg_wen) begin
				case (cfg_idx)
					RegDelimiter: delim_reg = cfg_data;
					RegQuote: quote_reg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				predict_beat(in_data, has_beat, beat);
				if (has_beat) expected_beats.push_back(beat);
			end
			if (out_valid && !out_stall) begin
				if (expected_beats.size() == 0) begin
					report_mismatch("output beat with nothing expected");
				end else begin
					want = expected_beats.pop_front();
					check_field("field_char", 16'(out_data.field_char), 16'(want.field_char));
					check_field("char_valid", 16'(out_data.char_valid), 16'(want.char_valid));
					check_field("field_end", 16'(out_data.field_end), 16'(want.field_end));
					check_field("row_end", 16'(out_data.row_end), 16'(want.row_end));
					check_field("empty_line", 16'(out_data.empty_line), 16'(want.empty_line));
					check_field("field_number", 16'(out_data.field_number),
						16'(want.field_number));
				end
			end
			pending <= expected_beats.size();
		end
	end

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// CSV line field parser testbench
// Drives directed lines and then random lines under several delimiter and
// quote settings and several idling patterns on both channels, including a
// long receiver hold-off and one line with more fields than the field number
// can count. The checker beside the block predicts and compares every beat;
// this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import cfp_pkg::*;

	localparam int LongHold    = 120;
	localparam int DrainCycles = 24;
	localparam int PhaseItems  = 64;
	localparam int NumPhases   = 8;

	localparam logic [ByteW-1:0] PhaseDelim [6] = '{8'd44, 8'd0, 8'd255, 8'h7C, 8'h3B, 8'h09};
	localparam logic [ByteW-1:0] PhaseQuote [6] = '{8'd34, 8'd255, 8'd0, 8'h27, 8'h3B, 8'h22};
	localparam int GapPct   [4] = '{0, 45, 0, 37};
	localparam int StallPct [4] = '{0, 0, 45, 37};

	localparam logic [ByteW-1:0] MixedLine [12] = '{
		8'h00, 8'hFF, QuoteReset, DelimiterReset, QuoteReset, DelimiterReset,
		QuoteReset, QuoteReset, QuoteReset, 8'h78, DelimiterReset, DelimiterReset
	};

	logic               clk;
	logic               arst_n;
	logic               cfg_wen;
	logic [CfgIdxW-1:0] cfg_idx;
	logic [ByteW-1:0]   cfg_data;
	logic               in_valid;
	logic               in_stall;
	in_item_t           in_data;
	logic               out_valid;
	logic               out_stall;
	out_item_t          out_data;
	int                 fail_count;
	int                 pending;

	int                 send_gap_pct;
	int                 stall_pct;
	int                 hold_req;
	int                 items_sent;
	logic [ByteW-1:0]   cur_delim;
	logic [ByteW-1:0]   cur_quote;

	csv_line_field_parser i_dut (.*);

	csv_field_checker i_checker (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	initial begin
		#4_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = LongHold;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	task automatic send_item(input in_item_t item);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_byte(input logic [ByteW-1:0] b);
		send_item(in_item_t'{FuncByte, b});
	endtask

	task automatic end_line();
		send_item(in_item_t'{FuncEol, ByteW'($urandom_range(255))});
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic set_format(input logic [ByteW-1:0] delim, input logic [ByteW-1:0] quote);
		wait_idle();
		cfg_wen  <= 1'b1;
		cfg_idx  <= RegDelimiter;
		cfg_data <= delim;
		@(posedge clk);
		cfg_idx  <= RegQuote;
		cfg_data <= quote;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		cur_delim = delim;
		cur_quote = quote;
	endtask

	function automatic logic [ByteW-1:0] plain_byte();
		logic [ByteW-1:0] b;
		do b = ByteW'($urandom_range(255));
		while (b == cur_delim || b == cur_quote);
		return b;
	endfunction

	function automatic logic [ByteW-1:0] noise_byte();
		case ($urandom_range(3))
			0: return cur_delim;
			1: return cur_quote;
			default: return ByteW'($urandom_range(255));
		endcase
	endfunction

	task automatic send_random_line();
		int               n_fields;
		logic [ByteW-1:0] b;
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(12)) send_byte(noise_byte());
			end_line();
			return;
		end
		n_fields = $urandom_range(1, 5);
		for (int f = 0; f < n_fields; f++) begin
			if (f > 0) send_byte(cur_delim);
			case ($urandom_range(4))
				0: ;
				1, 2: begin
					send_byte(plain_byte());
					repeat ($urandom_range(5)) begin
						if ($urandom_range(9) == 0) send_byte(cur_quote);
						else send_byte(plain_byte());
					end
				end
				default: begin
					send_byte(cur_quote);
					repeat ($urandom_range(6)) begin
						b = noise_byte();
						if (b == cur_quote) send_byte(cur_quote);
						send_byte(b);
					end
					if (f < n_fields - 1 || $urandom_range(3) != 0) begin
						send_byte(cur_quote);
						if ($urandom_range(4) == 0) begin
							repeat ($urandom_range(1, 3)) send_byte(plain_byte());
						end
					end
				end
			endcase
		end
		if ($urandom_range(4) == 0) send_byte(cur_delim);
		end_line();
	endtask

	// Enough delimiters to run the field number into saturation.
	task automatic send_wide_line();
		int n_delims;
		n_delims = 0;
		while (n_delims < int'(MaxFieldIndex) + 8) begin
			if ($urandom_range(9) != 0) begin
				send_byte(cur_delim);
				n_delims++;
			end else begin
				send_byte(plain_byte());
			end
		end
		end_line();
	endtask

	initial begin
		int start;
		int line_no;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		cfg_wen      = 1'b0;
		cfg_idx      = RegDelimiter;
		cfg_data     = '0;
		send_gap_pct = 0;
		stall_pct    = 0;
		hold_req     = 0;
		items_sent   = 0;
		cur_delim    = DelimiterReset;
		cur_quote    = QuoteReset;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		end_line();
		foreach (MixedLine[i]) send_byte(MixedLine[i]);
		end_line();
		send_byte(cur_quote);
		send_byte(8'h41);
		end_line();
		send_byte(cur_quote);
		send_byte(8'h41);
		send_byte(cur_quote);
		end_line();

		for (int p = 0; p < NumPhases; p++) begin
			set_format(PhaseDelim[p % 6], PhaseQuote[p % 6]);
			send_gap_pct = GapPct[p % 4];
			stall_pct    = StallPct[p % 4];
			if (p == 0) send_wide_line();
			start   = items_sent;
			line_no = 0;
			while (items_sent - start < PhaseItems) begin
				send_random_line();
				line_no++;
				if (p == 2 && line_no == 1) hold_req <= hold_req + 1;
				if (p == 3 && line_no == 4) wait_idle();
			end
		end

		wait_idle();
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
